// ===== rtl/lci3d_pkg.sv =====
// Shared widths, codes and payload types of the line and circle intersection unit.
package lci3d_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam logic [2:0] ST_TWO_POINTS   = 3'd0;
    localparam logic [2:0] ST_TANGENT      = 3'd1;
    localparam logic [2:0] ST_NOT_COPLANAR = 3'd2;
    localparam logic [2:0] ST_NO_HIT       = 3'd3;
    localparam logic [2:0] ST_ZERO_DIR     = 3'd4;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_NORMAL_Z = 3'd5;
    localparam logic [2:0] REG_RADIUS   = 3'd6;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] start_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
    } t_req;

    typedef struct packed {
        logic [2:0]                    status;
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] first_z;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] second_z;
        logic                          saturated;
    } t_res;

endpackage

// ===== rtl/line_circle_intersect_3d_unit.sv =====
// Line and circle intersection in 3D: register port and fully pipelined datapath.
//
// One request is taken every cycle; busy stays low. Each result appears on o_res with o_done
// high for one cycle. Its path: registers for the differences, products, dot sums and the
// discriminant, a 68-stage square root of the discriminant (one root bit per stage),
// registers forming the root numerators and their direction products, and a 36-stage
// restoring divider per coordinate (one quotient bit per stage), then the output register.
// Results leave in request order and cannot be held off.
// Circle registers must be written only while no request is in flight.
module line_circle_intersect_3d_unit
    import lci3d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W    = COORD_WIDTH;
    localparam int PW   = W + 1;          // s - C
    localparam int AW   = 2 * W + 1;      // a = d.d, signed, never negative
    localparam int DTW  = 2 * W + 2;      // d.n
    localparam int HW   = 2 * W + 3;      // h = d.p
    localparam int CW   = 2 * W + 5;      // c = p.p - r*r
    localparam int HK   = W + 2;          // split point of the wide multiplies
    localparam int DW   = 4 * W + 8;      // discriminant
    localparam int SQ   = DW / 2;         // root bits
    localparam int RW   = SQ + 2;
    localparam int NW   = SQ + 2;         // numerator -h +/- q
    localparam int NK   = NW / 2;         // split point of the numerator
    localparam int MW   = W + NW;
    localparam int XW   = MW + 2;         // 2*d*num + a
    localparam int QD   = W + 4;          // quotient bits
    localparam int DENW = AW + 1;         // 2*a
    localparam int VW   = W + QD + 2;

    localparam logic [W-1:0] NORMAL_Z_RESET = W'(1) << FRAC_BITS;
    localparam logic signed [VW-1:0] VMAX = (VW'(1) <<< (W - 1)) - VW'(1);
    localparam logic signed [VW-1:0] VMIN = -(VW'(1) <<< (W - 1));

    typedef struct packed {
        logic [2:0]                status;
        logic [2:0][W-1:0]         s;
        logic [2:0][W-1:0]         d;
        logic signed [AW-1:0]      a;
        logic signed [HW-1:0]      h;
    } t_cry;

    typedef struct packed {
        logic [DENW-1:0] rem;
        logic [QD-1:0]   lo;
        logic [QD-1:0]   quo;
        logic            neg;
    } t_lane;

    // ---------------- configuration registers ----------------
    logic signed [W-1:0] r_cen [3];
    logic signed [W-1:0] r_nrm [3];
    logic [W-2:0]        r_rad;
    logic [2:0]          cfg_idx;

    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen[0] <= '0;
            r_cen[1] <= '0;
            r_cen[2] <= '0;
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= NORMAL_Z_RESET;
            r_rad    <= '0;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_CENTER_X: r_cen[0] <= pwdata;
                REG_CENTER_Y: r_cen[1] <= pwdata;
                REG_CENTER_Z: r_cen[2] <= pwdata;
                REG_NORMAL_X: r_nrm[0] <= pwdata;
                REG_NORMAL_Y: r_nrm[1] <= pwdata;
                REG_NORMAL_Z: r_nrm[2] <= pwdata;
                REG_RADIUS:   r_rad    <= pwdata[W-2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_CENTER_X: prdata = r_cen[0];
            REG_CENTER_Y: prdata = r_cen[1];
            REG_CENTER_Z: prdata = r_cen[2];
            REG_NORMAL_X: prdata = r_nrm[0];
            REG_NORMAL_Y: prdata = r_nrm[1];
            REG_NORMAL_Z: prdata = r_nrm[2];
            REG_RADIUS:   prdata = {1'b0, r_rad};
            default:      prdata = '0;
        endcase
    end

    // ---------------- stage 1: capture, p = s - C ----------------
    logic signed [W-1:0]  in_s [3];
    logic signed [W-1:0]  in_d [3];
    logic                 r_v1;
    logic signed [W-1:0]  r_s1 [3];
    logic signed [W-1:0]  r_d1 [3];
    logic signed [PW-1:0] r_p1 [3];

    assign in_s[0] = i_req.start_x;
    assign in_s[1] = i_req.start_y;
    assign in_s[2] = i_req.start_z;
    assign in_d[0] = i_req.dir_x;
    assign in_d[1] = i_req.dir_y;
    assign in_d[2] = i_req.dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1[i] <= in_s[i];
            r_d1[i] <= in_d[i];
            r_p1[i] <= PW'(in_s[i]) - PW'(r_cen[i]);
        end
    end

    // ---------------- stage 2: coordinate products ----------------
    logic                   r_v2;
    logic signed [W-1:0]    r_s2 [3];
    logic signed [W-1:0]    r_d2 [3];
    logic signed [2*W-1:0]  r_dd [3];
    logic signed [2*W-1:0]  r_dn [3];
    logic signed [2*W:0]    r_dp [3];
    logic signed [2*W+1:0]  r_pp [3];
    logic [2*W-3:0]         r_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s2[i] <= r_s1[i];
            r_d2[i] <= r_d1[i];
            r_dd[i] <= (2*W)'(r_d1[i]) * (2*W)'(r_d1[i]);
            r_dn[i] <= (2*W)'(r_d1[i]) * (2*W)'(r_nrm[i]);
            r_dp[i] <= (2*W+1)'(r_d1[i]) * (2*W+1)'(r_p1[i]);
            r_pp[i] <= (2*W+2)'(r_p1[i]) * (2*W+2)'(r_p1[i]);
        end
        r_rr <= (2*W-2)'(r_rad) * (2*W-2)'(r_rad);
    end

    // ---------------- stage 3: dot sums ----------------
    logic                  r_v3;
    logic signed [W-1:0]   r_s3 [3];
    logic signed [W-1:0]   r_d3 [3];
    logic signed [AW-1:0]  r_a3;
    logic signed [DTW-1:0] r_dot3;
    logic signed [HW-1:0]  r_h3;
    logic signed [CW-1:0]  r_c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s3[i] <= r_s2[i];
            r_d3[i] <= r_d2[i];
        end
        r_a3   <= AW'(r_dd[0]) + AW'(r_dd[1]) + AW'(r_dd[2]);
        r_dot3 <= DTW'(r_dn[0]) + DTW'(r_dn[1]) + DTW'(r_dn[2]);
        r_h3   <= HW'(r_dp[0]) + HW'(r_dp[1]) + HW'(r_dp[2]);
        r_c3   <= CW'(r_pp[0]) + CW'(r_pp[1]) + CW'(r_pp[2])
                  - CW'($signed({1'b0, r_rr}));
    end

    // ---------------- stage 4: split products of h*h and a*c ----------------
    logic                         r_v4;
    t_cry                         r_c4;
    logic                         r_za4;
    logic                         r_nz4;
    logic signed [2*(HW-HK)-1:0]  r_hh2;
    logic signed [HW:0]           r_hh1;
    logic signed [2*HK+1:0]       r_hh0;
    logic signed [AW+CW-2*HK-1:0] r_ac2;
    logic signed [AW:0]           r_ac1a;
    logic signed [CW:0]           r_ac1b;
    logic signed [2*HK+1:0]       r_ac0;
    logic signed [HW-HK-1:0]      h_hi;
    logic signed [HK:0]           h_lo;
    logic signed [AW-HK-1:0]      a_hi;
    logic signed [HK:0]           a_lo;
    logic signed [CW-HK-1:0]      c_hi;
    logic signed [HK:0]           c_lo;

    assign h_hi = r_h3[HW-1:HK];
    assign h_lo = $signed({1'b0, r_h3[HK-1:0]});
    assign a_hi = r_a3[AW-1:HK];
    assign a_lo = $signed({1'b0, r_a3[HK-1:0]});
    assign c_hi = r_c3[CW-1:HK];
    assign c_lo = $signed({1'b0, r_c3[HK-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_c4.s[i] <= r_s3[i];
            r_c4.d[i] <= r_d3[i];
        end
        r_c4.status <= ST_TWO_POINTS;
        r_c4.a      <= r_a3;
        r_c4.h      <= r_h3;
        r_za4       <= (r_a3 == '0);
        r_nz4       <= (r_dot3 != '0);
        r_hh2       <= (2*(HW-HK))'(h_hi) * (2*(HW-HK))'(h_hi);
        r_hh1       <= (HW+1)'(h_hi) * (HW+1)'(h_lo);
        r_hh0       <= (2*HK+2)'(h_lo) * (2*HK+2)'(h_lo);
        r_ac2       <= (AW+CW-2*HK)'(a_hi) * (AW+CW-2*HK)'(c_hi);
        r_ac1a      <= (AW+1)'(a_hi) * (AW+1)'(c_lo);
        r_ac1b      <= (CW+1)'(a_lo) * (CW+1)'(c_hi);
        r_ac0       <= (2*HK+2)'(a_lo) * (2*HK+2)'(c_lo);
    end

    // ---------------- stage 5 and square root pipeline ----------------
    logic               r_sq_v    [0:SQ];
    t_cry               r_sq_c    [0:SQ];
    logic [RW-1:0]      r_sq_rem  [0:SQ];
    logic [SQ-1:0]      r_sq_root [0:SQ];
    logic [DW-1:0]      r_sq_rad  [0:SQ];
    logic signed [DW-1:0] disc;
    logic [2:0]         st5;
    t_cry               c5;

    assign disc = (DW'(r_hh2) <<< (2 * HK)) + (DW'(r_hh1) <<< (HK + 1)) + DW'(r_hh0)
                - (DW'(r_ac2) <<< (2 * HK)) - ((DW'(r_ac1a) + DW'(r_ac1b)) <<< HK)
                - DW'(r_ac0);

    always_comb begin
        if (r_za4) begin
            st5 = ST_ZERO_DIR;
        end else if (r_nz4) begin
            st5 = ST_NOT_COPLANAR;
        end else if (disc[DW-1]) begin
            st5 = ST_NO_HIT;
        end else if (disc == '0) begin
            st5 = ST_TANGENT;
        end else begin
            st5 = ST_TWO_POINTS;
        end
    end

    always_comb begin
        c5        = r_c4;
        c5.status = st5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_c[0]        <= c5;
        r_sq_rem[0]      <= '0;
        r_sq_root[0]     <= '0;
        r_sq_rad[0]      <= disc[DW-1] ? '0 : disc;
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sq
        logic [RW-1:0] rem2;
        logic [RW-1:0] trial;

        assign rem2  = {r_sq_rem[j][RW-3:0], r_sq_rad[j][DW-1:DW-2]};
        assign trial = {r_sq_root[j], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j+1] <= 1'b0;
            end else begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_c[j+1]   <= r_sq_c[j];
            r_sq_rad[j+1] <= r_sq_rad[j] << 2;
            if (rem2 >= trial) begin
                r_sq_rem[j+1]  <= rem2 - trial;
                r_sq_root[j+1] <= {r_sq_root[j][SQ-2:0], 1'b1};
            end else begin
                r_sq_rem[j+1]  <= rem2;
                r_sq_root[j+1] <= {r_sq_root[j][SQ-2:0], 1'b0};
            end
        end
    end

    // ---------------- stage 6: numerators q - h and -(h + q) ----------------
    logic                 r_v6;
    t_cry                 r_c6;
    logic signed [NW-1:0] r_num [2];
    logic signed [NW-1:0] q_ext;

    assign q_ext = $signed({2'b00, r_sq_root[SQ]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_sq_v[SQ];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c6     <= r_sq_c[SQ];
        r_num[0] <= q_ext - NW'(r_sq_c[SQ].h);
        r_num[1] <= -(q_ext + NW'(r_sq_c[SQ].h));
    end

    // ---------------- stage 7: d_i * numerator, in two halves ----------------
    logic                      r_v7;
    t_cry                      r_c7;
    logic signed [W+NW-NK-1:0] r_ph [6];
    logic signed [W+NK:0]      r_pl [6];
    logic signed [NW-NK-1:0]   num_hi [2];
    logic signed [NK:0]        num_lo [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            num_hi[k] = r_num[k][NW-1:NK];
            num_lo[k] = $signed({1'b0, r_num[k][NK-1:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c7 <= r_c6;
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                r_ph[k*3+i] <= (W+NW-NK)'($signed(r_c6.d[i])) * (W+NW-NK)'(num_hi[k]);
                r_pl[k*3+i] <= (W+NK+1)'($signed(r_c6.d[i])) * (W+NK+1)'(num_lo[k]);
            end
        end
    end

    // ---------------- stage 8 and divider pipeline ----------------
    logic          r_dv_v [0:QD];
    t_cry          r_dv_c [0:QD];
    t_lane         r_dv_l [0:QD][6];
    logic [DENW-1:0] den [0:QD-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_v7;
        end
    end

    for (genvar l = 0; l < 6; l++) begin : g_lane
        logic signed [XW-1:0] m;
        logic [XW-1:0]        mag;

        assign m   = (XW'(r_ph[l]) <<< (NK + 1)) + (XW'(r_pl[l]) <<< 1) + XW'(r_c7.a);
        assign mag = m[XW-1] ? -m : m;

        always_ff @(posedge i_clk) begin
            r_dv_l[0][l].neg <= m[XW-1];
            r_dv_l[0][l].rem <= mag[QD+DENW-1:QD];
            r_dv_l[0][l].lo  <= mag[QD-1:0];
            r_dv_l[0][l].quo <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_c[0] <= r_c7;
    end

    for (genvar j = 0; j < QD; j++) begin : g_den
        assign den[j] = {r_dv_c[j].a[AW-2:0], 1'b0};
    end

    for (genvar j = 0; j < QD; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_c[j+1] <= r_dv_c[j];
        end

        for (genvar l = 0; l < 6; l++) begin : g_dl
            logic [DENW:0] rem2;

            assign rem2 = {r_dv_l[j][l].rem, r_dv_l[j][l].lo[QD-1]};

            always_ff @(posedge i_clk) begin
                r_dv_l[j+1][l].neg <= r_dv_l[j][l].neg;
                r_dv_l[j+1][l].lo  <= r_dv_l[j][l].lo << 1;
                if (rem2 >= {1'b0, den[j]}) begin
                    r_dv_l[j+1][l].rem <= DENW'(rem2 - {1'b0, den[j]});
                    r_dv_l[j+1][l].quo <= {r_dv_l[j][l].quo[QD-2:0], 1'b1};
                end else begin
                    r_dv_l[j+1][l].rem <= rem2[DENW-1:0];
                    r_dv_l[j+1][l].quo <= {r_dv_l[j][l].quo[QD-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- output: floor correction, offset, clamp ----------------
    logic signed [W-1:0] coord [6];
    logic                clip  [6];
    logic                r_done;
    t_res                r_res;
    t_res                n_res;
    t_cry                fc;

    assign fc = r_dv_c[QD];

    for (genvar l = 0; l < 6; l++) begin : g_out
        logic signed [QD+1:0] qs;
        logic signed [VW-1:0] v;
        t_lane                fl;

        assign fl = r_dv_l[QD][l];
        // negative numerators round toward minus infinity
        assign qs = fl.neg ? -($signed({2'b00, fl.quo}) + (QD+2)'(fl.rem != '0))
                           : $signed({2'b00, fl.quo});
        assign v  = VW'($signed(fc.s[l % 3])) + VW'(qs);

        always_comb begin
            if (v > VMAX) begin
                coord[l] = VMAX[W-1:0];
                clip[l]  = 1'b1;
            end else if (v < VMIN) begin
                coord[l] = VMIN[W-1:0];
                clip[l]  = 1'b1;
            end else begin
                coord[l] = v[W-1:0];
                clip[l]  = 1'b0;
            end
        end
    end

    always_comb begin
        n_res        = '0;
        n_res.status = fc.status;
        if (fc.status == ST_TWO_POINTS || fc.status == ST_TANGENT) begin
            n_res.first_x   = coord[0];
            n_res.first_y   = coord[1];
            n_res.first_z   = coord[2];
            n_res.second_x  = coord[3];
            n_res.second_y  = coord[4];
            n_res.second_z  = coord[5];
            n_res.saturated = clip[0] | clip[1] | clip[2] | clip[3] | clip[4] | clip[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv_v[QD];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
